>>> src/lmco_pkg.sv
`default_nettype none
package lmco_pkg;

    localparam int MUL_W   = 32;   // serial multiplier operand width
    localparam int ROOT_W  = 26;   // square root result width
    localparam int RAD_W   = 2 * ROOT_W;

    localparam logic [24:0] Q24_ONE     = 25'd16777216;
    localparam logic [25:0] PHASE_RESET = 26'd18454938;
    localparam logic [15:0] COEF_MIN    = 16'd32768;
    localparam logic [15:0] COEF_MAX    = 16'd65534;
    localparam logic [15:0] NEXT_RESET  = 16'd32768;
    localparam logic [15:0] EXP_ONE     = 16'd4096;
    localparam logic [17:0] RATE_RESET  = 18'd48000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV,
        S_PHASE,
        S_POW_SEL,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ROOT_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_CX,
        M_CXX,
        M_PINT,
        M_ROOT,
        M_OUT
    } t_mop;

    // Q.24 product, truncated and capped at 2^32-1
    function automatic logic [31:0] q24_cap(input logic [63:0] p);
        logic [31:0] r;
        begin
            if (|p[63:56]) r = 32'hFFFF_FFFF;
            else           r = p[55:24];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> src/lmco_mul.sv
`default_nettype none
module lmco_mul
    import lmco_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_W-1:0]   i_a,
    input  wire logic [MUL_W-1:0]   i_b,
    output logic                    o_done,
    output logic [2*MUL_W-1:0]      o_prod
);

    localparam int CW = $clog2(MUL_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [MUL_W-1:0]     r_a;
    logic [2*MUL_W-1:0]   r_prod;
    logic [MUL_W:0]       sum;

    // add the multiplicand when the multiplier LSB is set, then shift right
    assign sum = {1'b0, r_prod[2*MUL_W-1:MUL_W]} + (r_prod[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{MUL_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {sum, r_prod[MUL_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> src/lmco_sqrt.sv
`default_nettype none
module lmco_sqrt
    import lmco_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [RAD_W-1:0]   i_rad,
    output logic                    o_done,
    output logic [ROOT_W-1:0]       o_root
);

    localparam int CW = $clog2(ROOT_W);
    localparam int RW = ROOT_W + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [RAD_W-1:0]     r_rad;
    logic [RW-1:0]        r_rem;
    logic [ROOT_W-1:0]    r_q;
    logic [RW-1:0]        t;
    logic [RW-1:0]        trial;
    logic                 ge;

    // restoring square root, two radicand bits per cycle
    assign t     = {r_rem[RW-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial = {r_q, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem <= ge ? (t - trial) : t;
            r_q   <= {r_q[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_q;

endmodule
`default_nettype wire

>>> src/logistic_map_chaos_oscillator.sv
// A transaction is shortest with no map update and an exponent of 0 or 1.0, and longest
// with a map update, a large integer exponent and all fraction bits set.
// Each multiply runs on the bit-serial multiplier, each root on the restoring root unit,
// and the phase step divide is bit-serial; these set how long a transaction takes.
// One transaction in flight; the next is taken while a result waits in the output register.
// Synchronous active-low reset: sample rate 48000, map value 0.5, phase 1.1 (first sample updates).
`default_nettype none
module logistic_map_chaos_oscillator
    import lmco_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic [17:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [19:0]        i_frequency,
    input  wire logic [15:0]        i_map_coefficient,
    input  wire logic [15:0]        i_curve_exponent,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [17:0]      o_sample_out
);

    t_state                 r_state, n_state;
    t_mop                   r_mop;
    logic [17:0]            r_sample_rate;
    logic [19:0]            r_freq;
    logic [15:0]            r_coef;
    logic [15:0]            r_curve;
    logic [15:0]            r_next;
    logic [15:0]            r_prev;
    logic [25:0]            r_phase;
    logic signed [16:0]     r_gap;
    logic [15:0]            r_held;
    logic [31:0]            r_tmp;
    logic [39:0]            r_dq;
    logic [17:0]            r_rem;
    logic [5:0]             r_dcnt;
    logic [31:0]            r_pw;
    logic [3:0]             r_n;
    logic [3:0]             r_k;
    logic [ROOT_W-1:0]      r_root;
    logic [24:0]            r_mag;
    logic                   r_out_valid;
    logic signed [17:0]     r_sample_out;

    logic                   accept;
    logic                   mul_start, mul_done;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]      sqrt_q;
    logic                   out_load;
    logic [18:0]            d_t;
    logic                   d_ge;
    logic [18:0]            d_sub;
    logic [24:0]            step;
    logic [15:0]            coef_c;
    logic [16:0]            gap_abs;
    logic [15:0]            map_new;
    logic signed [26:0]     sum;
    logic signed [17:0]     sum_sat;

    assign accept = i_valid && !o_stall;

    // divider step: remainder and next dividend bit against the sample rate
    assign d_t   = {r_rem, r_dq[39]};
    assign d_ge  = (d_t >= {1'b0, r_sample_rate});
    assign d_sub = d_t - {1'b0, r_sample_rate};

    always_comb begin
        if (r_freq == '0)            step = '0;
        else if (r_dq > 40'(Q24_ONE)) step = Q24_ONE;
        else                         step = r_dq[24:0];
    end

    always_comb begin
        if (r_coef > COEF_MAX)      coef_c = COEF_MAX;
        else if (r_coef < COEF_MIN) coef_c = COEF_MIN;
        else                        coef_c = r_coef;
    end

    assign gap_abs = r_gap[16] ? 17'(-r_gap) : 17'(r_gap);
    assign map_new = mul_p[45:30];

    assign sum = r_gap[16] ? (27'(r_prev) - 27'(r_mag)) : (27'(r_prev) + 27'(r_mag));
    always_comb begin
        if (sum > 27'sd131071)       sum_sat = 18'sd131071;
        else if (sum < -27'sd131072) sum_sat = -18'sd131072;
        else                         sum_sat = sum[17:0];
    end

    always_comb begin
        case (r_mop)
            M_CX: begin
                mul_a = {16'b0, r_coef};
                mul_b = {16'b0, r_prev};
            end
            M_CXX: begin
                mul_a = r_tmp;
                mul_b = {15'b0, 17'h10000 - {1'b0, r_prev}};
            end
            M_PINT: begin
                mul_a = r_pw;
                mul_b = {6'b0, r_phase};
            end
            M_ROOT: begin
                mul_a = r_pw;
                mul_b = {6'b0, r_root};
            end
            M_OUT: begin
                mul_a = r_pw;
                mul_b = {15'b0, gap_abs};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = (r_phase > 26'(Q24_ONE)) ? S_UPDATE : S_DIV_GO;
            end
            S_UPDATE:   n_state = S_MUL_GO;
            S_MUL_GO:   n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_mop)
                        M_CX:    n_state = S_MUL_GO;
                        M_CXX:   n_state = S_DIV_GO;
                        M_PINT:  n_state = (r_n == 4'd1) ? S_SQRT_GO : S_MUL_GO;
                        M_ROOT:  n_state = S_ROOT_NEXT;
                        M_OUT:   n_state = S_DONE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV_GO:   n_state = S_DIV;
            S_DIV:      if (r_dcnt == 6'd39) n_state = S_PHASE;
            S_PHASE:    n_state = S_POW_SEL;
            S_POW_SEL: begin
                if (r_held == '0 || r_held == EXP_ONE || r_held[15:12] != '0)
                    n_state = S_MUL_GO;
                else
                    n_state = S_SQRT_GO;
            end
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (sqrt_done) n_state = r_held[r_k] ? S_MUL_GO : S_ROOT_NEXT;
            end
            S_ROOT_NEXT: n_state = (r_k == '0) ? S_MUL_GO : S_SQRT_GO;
            S_DONE:      if (!r_out_valid || !i_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall    = (r_state != S_IDLE);
        mul_start  = (r_state == S_MUL_GO);
        sqrt_start = (r_state == S_SQRT_GO);
        out_load   = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sample_rate <= RATE_RESET;
            r_next        <= NEXT_RESET;
            r_prev        <= '0;
            r_phase       <= PHASE_RESET;
            r_gap         <= '0;
            r_held        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) r_sample_rate <= i_cfg_wdata;
            if (r_state == S_UPDATE) begin
                r_prev  <= r_next;
                r_phase <= '0;
                r_held  <= r_curve;
            end
            if (r_state == S_MUL_WAIT && mul_done && r_mop == M_CXX) begin
                r_next <= map_new;
                r_gap  <= $signed({1'b0, map_new} - {1'b0, r_prev});
            end
            if (r_state == S_PHASE) r_phase <= r_phase + 26'(step);
            if (out_load)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_freq  <= i_frequency;
            r_coef  <= i_map_coefficient;
            r_curve <= i_curve_exponent;
        end
        case (r_state)
            S_UPDATE: begin
                r_coef <= coef_c;
                r_mop  <= M_CX;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_mop)
                        M_CX: begin
                            r_tmp <= mul_p[31:0];
                            r_mop <= M_CXX;
                        end
                        M_PINT: begin
                            r_pw <= q24_cap(mul_p);
                            r_n  <= r_n - 1'b1;
                        end
                        M_ROOT:  r_pw  <= q24_cap(mul_p);
                        M_OUT:   r_mag <= mul_p[48:24];
                        default: ;
                    endcase
                end
            end
            S_DIV_GO: begin
                r_dq   <= {r_freq, 20'b0};
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_rem  <= d_ge ? d_sub[17:0] : d_t[17:0];
                r_dq   <= {r_dq[38:0], d_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            S_POW_SEL: begin
                r_n    <= r_held[15:12];
                r_k    <= 4'd11;
                r_root <= r_phase;
                if (r_held == '0) begin
                    r_pw  <= '0;
                    r_mop <= M_OUT;
                end else if (r_held == EXP_ONE) begin
                    r_pw  <= {6'b0, r_phase};
                    r_mop <= M_OUT;
                end else begin
                    r_pw  <= {7'b0, Q24_ONE};
                    r_mop <= M_PINT;
                end
            end
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_root <= sqrt_q;
                    r_mop  <= M_ROOT;
                end
            end
            S_ROOT_NEXT: begin
                if (r_k == '0) r_mop <= M_OUT;
                else           r_k   <= r_k - 1'b1;
            end
            default: ;
        endcase
        if (out_load) r_sample_out <= sum_sat;
    end

    lmco_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    lmco_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   ({r_root, 24'b0, 2'b00} >> 2),
        .o_done  (sqrt_done),
        .o_root  (sqrt_q)
    );

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_sample_out;

    a_mul_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_sqrt_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> r_state == S_SQRT_WAIT)
        else $error("root unit finished outside its wait state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("transaction accepted but sequencer stayed idle");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("result loaded but output not valid");

endmodule
`default_nettype wire
